@@ rtl/core/slpc_pkg.sv @@
package slpc_pkg;

  localparam int MAX_LEDS = 1024;
  localparam int LEN_W    = 11;
  localparam int POS_W    = 10;
  localparam int COLOR_W  = 24;
  localparam int CFG_W    = 24;
  localparam int IDX_W    = 3;
  localparam int DIV_N_W  = 32;
  localparam int DIV_D_W  = 16;
  localparam int Q_DEPTH  = 4;
  localparam int Q_AW     = 2;

  localparam logic [2:0] PH_IDLE     = 3'd0;
  localparam logic [2:0] PH_ARRIVING = 3'd1;
  localparam logic [2:0] PH_WORKING  = 3'd2;
  localparam logic [2:0] PH_DONE     = 3'd3;
  localparam logic [2:0] PH_CLEARING = 3'd4;

  localparam logic [IDX_W-1:0] REG_IDLE_COLOR     = 3'd0;
  localparam logic [IDX_W-1:0] REG_ARRIVING_COLOR = 3'd1;
  localparam logic [IDX_W-1:0] REG_CLEARING_COLOR = 3'd2;
  localparam logic [IDX_W-1:0] REG_BAND_WIDTH     = 3'd3;
  localparam logic [IDX_W-1:0] REG_BAND_STEP_MS   = 3'd4;

  // how the back end builds the color
  typedef enum logic [1:0] {
    CLS_FIXED,
    CLS_BAND,
    CLS_PULSE
  } cls_t;

  typedef struct packed {
    cls_t               cls;
    logic [POS_W-1:0]   pos;
    logic [LEN_W-1:0]   travel;
    logic [LEN_W-1:0]   bw;
    logic [15:0]        step;
    logic [31:0]        time_ms;
    logic [15:0]        period;
    logic [COLOR_W-1:0] color;
  } item_t;

  typedef struct packed {
    item_t it;
    logic  full;
  } mid_t;

  // exact x / 255 for x < 65280
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] s;
    s = {1'b0, x} + 17'd1 + {9'd0, x[15:8]};
    return s[15:8];
  endfunction

endpackage

@@ rtl/core/slpc_div.sv @@
module slpc_div import slpc_pkg::*; (
  input  logic               clk,
  input  logic               en,
  input  logic [DIV_N_W-1:0] num,
  input  logic [DIV_D_W-1:0] den,
  output logic [DIV_N_W-1:0] quo,
  output logic [DIV_D_W-1:0] rem
);

  // restoring divider, one quotient bit per stage
  logic [DIV_N_W-1:0] n_q [DIV_N_W];
  logic [DIV_D_W-1:0] r_q [DIV_N_W];
  logic [DIV_D_W-1:0] d_q [DIV_N_W];
  logic [DIV_N_W-1:0] q_q [DIV_N_W];

  for (genvar i = 0; i < DIV_N_W; i++) begin : g_stage
    logic [DIV_N_W-1:0] n_in;
    logic [DIV_D_W-1:0] r_in;
    logic [DIV_D_W-1:0] d_in;
    logic [DIV_N_W-1:0] q_in;
    logic [DIV_D_W:0]   trial;
    logic [DIV_D_W:0]   diff;
    logic               take;

    if (i == 0) begin : g_first
      assign n_in = num;
      assign r_in = '0;
      assign d_in = den;
      assign q_in = '0;
    end else begin : g_next
      assign n_in = n_q[i-1];
      assign r_in = r_q[i-1];
      assign d_in = d_q[i-1];
      assign q_in = q_q[i-1];
    end

    always_comb begin
      trial = {r_in, n_in[DIV_N_W-1]};
      diff  = trial - {1'b0, d_in};
      take  = (trial >= {1'b0, d_in});
    end

    always_ff @(posedge clk) begin
      if (en) begin
        n_q[i] <= {n_in[DIV_N_W-2:0], 1'b0};
        r_q[i] <= take ? diff[DIV_D_W-1:0] : trial[DIV_D_W-1:0];
        d_q[i] <= d_in;
        q_q[i] <= {q_in[DIV_N_W-2:0], take};
      end
    end
  end

  assign quo = q_q[DIV_N_W-1];
  assign rem = r_q[DIV_N_W-1];

endmodule

@@ rtl/core/slpc_front.sv @@
module slpc_front import slpc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               wr_en,
  input  logic [IDX_W-1:0]   wr_index,
  input  logic [CFG_W-1:0]   wr_data,
  input  logic [2:0]         phase,
  input  logic [POS_W-1:0]   led_position,
  input  logic [LEN_W-1:0]   zone_length,
  input  logic [31:0]        time_ms,
  input  logic [COLOR_W-1:0] pulse_color,
  input  logic [15:0]        pulse_period_ms,
  output item_t              item
);

  logic [COLOR_W-1:0] idle_color;
  logic [COLOR_W-1:0] arriving_color;
  logic [COLOR_W-1:0] clearing_color;
  logic [LEN_W-1:0]   band_width;
  logic [15:0]        band_step_ms;

  always_ff @(posedge clk) begin
    if (rst) begin
      idle_color     <= '0;
      arriving_color <= '0;
      clearing_color <= '0;
      band_width     <= LEN_W'(1);
      band_step_ms   <= 16'd100;
    end else if (wr_en) begin
      case (wr_index)
        REG_IDLE_COLOR:     idle_color     <= wr_data;
        REG_ARRIVING_COLOR: arriving_color <= wr_data;
        REG_CLEARING_COLOR: clearing_color <= wr_data;
        REG_BAND_WIDTH:     band_width     <= wr_data[LEN_W-1:0];
        REG_BAND_STEP_MS:   band_step_ms   <= wr_data[15:0];
        default: ;
      endcase
    end
  end

  logic [LEN_W-1:0] len;

  always_comb begin
    len = (zone_length > LEN_W'(MAX_LEDS)) ? LEN_W'(MAX_LEDS) : zone_length;
    item.pos     = led_position;
    item.bw      = band_width;
    item.travel  = (len > band_width) ? len - band_width : '0;
    item.step    = (band_step_ms == '0) ? 16'd1 : band_step_ms;
    item.time_ms = time_ms;
    item.period  = pulse_period_ms;
    case (phase)
      PH_IDLE: begin
        item.cls   = CLS_FIXED;
        item.color = idle_color;
      end
      PH_ARRIVING: begin
        item.cls   = CLS_BAND;
        item.color = arriving_color;
      end
      PH_WORKING: begin
        item.cls   = CLS_PULSE;
        item.color = pulse_color;
      end
      PH_DONE: begin
        item.cls   = CLS_FIXED;
        item.color = pulse_color;
      end
      PH_CLEARING: begin
        item.cls   = CLS_BAND;
        item.color = clearing_color;
      end
      default: begin
        item.cls   = CLS_FIXED;
        item.color = '0;
      end
    endcase
  end

endmodule

@@ rtl/core/slpc_queue.sv @@
module slpc_queue import slpc_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t push_item,
  input  logic  pop,
  output item_t head,
  output logic  full,
  output logic  empty
);

  item_t           mem [Q_DEPTH];
  logic [Q_AW-1:0] wp;
  logic [Q_AW-1:0] rp;
  logic [Q_AW:0]   cnt;

  assign full  = (cnt == (Q_AW+1)'(Q_DEPTH));
  assign empty = (cnt == '0);
  assign head  = mem[rp];

  always_ff @(posedge clk) begin
    if (push) mem[wp] <= push_item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (push) wp <= wp + 1'b1;
      if (pop)  rp <= rp + 1'b1;
      if (push && !pop)      cnt <= cnt + 1'b1;
      else if (pop && !push) cnt <= cnt - 1'b1;
    end
  end

endmodule

@@ rtl/core/slpc_back.sv @@
module slpc_back import slpc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       en,
  input  logic       in_v,
  input  item_t      in_item,
  output logic       out_v,
  output logic [7:0] red,
  output logic [7:0] green,
  output logic [7:0] blue
);

  // first divider pair: time / step and time % period
  logic [DIV_N_W-1:0] qa;
  logic [DIV_D_W-1:0] ra_unused_q;
  logic [DIV_N_W-1:0] qb_unused;
  logic [DIV_D_W-1:0] rb;

  slpc_div u_div_step (.clk, .en, .num(in_item.time_ms), .den(in_item.step),
                       .quo(qa), .rem(ra_unused_q));
  slpc_div u_div_per  (.clk, .en, .num(in_item.time_ms), .den(in_item.period),
                       .quo(qb_unused), .rem(rb));

  item_t sa [DIV_N_W];
  logic  va [DIV_N_W];

  always_ff @(posedge clk) begin
    if (en) begin
      sa[0] <= in_item;
      for (int i = 1; i < DIV_N_W; i++) sa[i] <= sa[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DIV_N_W; i++) va[i] <= 1'b0;
    end else if (en) begin
      va[0] <= in_v;
      for (int i = 1; i < DIV_N_W; i++) va[i] <= va[i-1];
    end
  end

  // prep: fold phase into triangle, build second divider operands
  item_t               p_item;
  logic                p_v;
  logic                p_full;
  logic [DIV_N_W-1:0]  p_q;
  logic [22:0]         p_dn;
  logic [LEN_W:0]      p_den;
  logic [14:0]         p_half;
  logic [14:0]         half;
  logic [15:0]         dtri;
  item_t               ta;

  always_comb begin
    ta   = sa[DIV_N_W-1];
    half = ta.period[15:1];
    dtri = (rb <= {1'b0, half}) ? rb : ta.period - rb;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_item <= ta;
      p_full <= (ta.period < 16'd2);
      p_q    <= qa;
      p_dn   <= 23'(dtri[14:0]) * 23'd255;
      p_den  <= {1'b0, ta.travel} + 1'b1;
      p_half <= half;
    end
  end

  always_ff @(posedge clk) begin
    if (rst)     p_v <= 1'b0;
    else if (en) p_v <= va[DIV_N_W-1];
  end

  // second divider pair: band start and breathing level
  logic [DIV_N_W-1:0] qc_unused;
  logic [DIV_D_W-1:0] start;
  logic [DIV_N_W-1:0] lvl_q;
  logic [DIV_D_W-1:0] rd_unused;

  slpc_div u_div_mod (.clk, .en, .num(p_q), .den(DIV_D_W'(p_den)),
                      .quo(qc_unused), .rem(start));
  slpc_div u_div_lvl (.clk, .en, .num(DIV_N_W'(p_dn)), .den({1'b0, p_half}),
                      .quo(lvl_q), .rem(rd_unused));

  mid_t sb [DIV_N_W];
  logic vb [DIV_N_W];

  always_ff @(posedge clk) begin
    if (en) begin
      sb[0] <= '{it: p_item, full: p_full};
      for (int i = 1; i < DIV_N_W; i++) sb[i] <= sb[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DIV_N_W; i++) vb[i] <= 1'b0;
    end else if (en) begin
      vb[0] <= p_v;
      for (int i = 1; i < DIV_N_W; i++) vb[i] <= vb[i-1];
    end
  end

  // finish: band test and channel products
  mid_t        tb;
  logic [7:0]  level;
  logic [LEN_W:0] band_end;
  logic        f_v;
  logic        f_lit;
  cls_t        f_cls;
  logic [COLOR_W-1:0] f_color;
  logic [15:0] f_pr;
  logic [15:0] f_pg;
  logic [15:0] f_pb;

  always_comb begin
    tb       = sb[DIV_N_W-1];
    level    = tb.full ? 8'd255 : lvl_q[7:0];
    band_end = {1'b0, start[LEN_W-1:0]} + {1'b0, tb.it.bw};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f_lit   <= ({1'b0, tb.it.pos} >= start[LEN_W-1:0]) &&
                 ({2'b0, tb.it.pos} < band_end);
      f_cls   <= tb.it.cls;
      f_color <= tb.it.color;
      f_pr    <= {8'd0, tb.it.color[23:16]} * {8'd0, level};
      f_pg    <= {8'd0, tb.it.color[15:8]} * {8'd0, level};
      f_pb    <= {8'd0, tb.it.color[7:0]} * {8'd0, level};
    end
  end

  always_ff @(posedge clk) begin
    if (rst)     f_v <= 1'b0;
    else if (en) f_v <= vb[DIV_N_W-1];
  end

  // output register
  logic [COLOR_W-1:0] rgb;

  always_comb begin
    case (f_cls)
      CLS_BAND:  rgb = f_lit ? f_color : '0;
      CLS_PULSE: rgb = {div255(f_pr), div255(f_pg), div255(f_pb)};
      default:   rgb = f_color;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      red   <= rgb[23:16];
      green <= rgb[15:8];
      blue  <= rgb[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst)     out_v <= 1'b0;
    else if (en) out_v <= f_v;
  end

endmodule

@@ rtl/core/status_led_pattern_color.sv @@
// Status LED color: one item in (zone phase, LED position, zone length, ms clock,
// zone pulse color and period), one item out (8-bit red, green, blue). An item
// is taken every cycle when nothing downstream stalls; each item passes through
// two 32-stage pipelined dividers in series (time / step and time % period,
// then start = quotient % (travel+1) and the breathing level).
// Config registers (wr_index): 0 idle color, 1 arriving color, 2 clearing
// color, 3 band width, 4 band step in ms; write them only while idle. Colors
// are 0xRRGGBB. Config is sampled into each item when accepted.
module status_led_pattern_color import slpc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               wr_en,
  input  logic [IDX_W-1:0]   wr_index,
  input  logic [CFG_W-1:0]   wr_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         phase,
  input  logic [POS_W-1:0]   led_position,
  input  logic [LEN_W-1:0]   zone_length,
  input  logic [31:0]        time_ms,
  input  logic [COLOR_W-1:0] pulse_color,
  input  logic [15:0]        pulse_period_ms,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         red,
  output logic [7:0]         green,
  output logic [7:0]         blue
);

  item_t cls_item;
  item_t head;
  logic  q_full;
  logic  q_empty;
  logic  adv;
  logic  push;
  logic  pop;

  // front: config regs and per-phase classification
  slpc_front u_front (
    .clk, .rst, .wr_en, .wr_index, .wr_data,
    .phase, .led_position, .zone_length, .time_ms, .pulse_color, .pulse_period_ms,
    .item(cls_item)
  );

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  // whole back pipeline freezes only when a finished item sits stalled
  assign adv = !out_valid || !out_stall;
  assign pop = adv && !q_empty;

  slpc_queue u_queue (
    .clk, .rst, .push, .push_item(cls_item), .pop,
    .head, .full(q_full), .empty(q_empty)
  );

  slpc_back u_back (
    .clk, .rst, .en(adv), .in_v(pop), .in_item(head),
    .out_v(out_valid), .red, .green, .blue
  );

endmodule

@@ rtl/core/slpc_checker.sv @@
module slpc_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] red,
  input logic [7:0] green,
  input logic [7:0] blue
);

  a_rst_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out_valid after reset");

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("stalled item dropped");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(red) && $stable(green) && $stable(blue))
    else $error("stalled item changed");

  a_no_early: assert property (@(posedge clk)
    !rst && $past(rst) |-> !out_valid)
    else $error("item appears right after reset");

endmodule

bind status_led_pattern_color slpc_checker u_chk (
  .clk, .rst, .out_valid, .out_stall, .red, .green, .blue
);
